@@ rtl/turtle_plotter_raster_assert.svh @@
// Assertion macros for the turtle plotter raster block.
// Used by rtl/turtle_plotter_raster.sv; needs a clock named clock and a reset named reset.
`ifndef TURTLE_PLOTTER_RASTER_ASSERT_SVH
`define TURTLE_PLOTTER_RASTER_ASSERT_SVH

// Condition must hold on every rising clock edge outside reset.
`define TPR_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("tpr assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define TPR_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tpr assertion failed");

`endif

@@ rtl/tpr_pkg.sv @@
// Package for the turtle plotter raster: sizes, command and heading codes, state and payload types.
// No dependencies; imported by rtl/turtle_plotter_raster.sv.
package tpr_pkg;

   localparam int unsigned GRID_SIZE = 64;
   localparam int unsigned IDX_W     = $clog2(GRID_SIZE);
   localparam int unsigned ROW_W     = 64;
   localparam int unsigned SH_W      = $clog2(ROW_W) + 1;
   localparam int unsigned POS_W     = 16;
   localparam int unsigned EXT_W     = POS_W + 2;
   localparam int unsigned KIND_W    = 3;
   localparam int unsigned STEPS_W   = 8;
   localparam int unsigned RIDX_W    = 6;

   localparam logic [ROW_W-1:0] GRID_MASK = {ROW_W{1'b1}} >> (ROW_W - GRID_SIZE);

   // command codes
   localparam logic [KIND_W-1:0] KIND_PEN_UP    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PEN_DOWN  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TURN_R    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_TURN_L    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_MOVE      = 3'd4;
   localparam logic [KIND_W-1:0] KIND_READ_OUT  = 3'd5;

   // heading codes
   localparam logic [1:0] HEAD_NEG_Y = 2'd0;
   localparam logic [1:0] HEAD_POS_X = 2'd1;
   localparam logic [1:0] HEAD_POS_Y = 2'd2;
   localparam logic [1:0] HEAD_NEG_X = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOVE_SETUP,
      ST_MOVE_RUN,
      ST_MOVE_DRAIN,
      ST_DUMP
   } state_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [STEPS_W-1:0] steps;
   } req_payload_type;

   typedef struct packed {
      logic [RIDX_W-1:0] row_index;
      logic [ROW_W-1:0]  row_bits;
      logic              last_row;
   } rsp_payload_type;

endpackage

@@ rtl/turtle_plotter_raster.sv @@
// Turtle plotter raster top level: command sequencer around a row memory of the bit grid.
// Depends on rtl/tpr_pkg.sv and rtl/turtle_plotter_raster_assert.svh.
//
// Usage:
//  - req channel (req_valid/req_ready/req_payload) takes one command per transfer:
//    pen up, pen down, turn right, turn left, move n steps, read out.
//  - rsp channel (rsp_valid/rsp_ready/rsp_payload) carries grid rows; only read out
//    produces transfers, GRID_SIZE of them, rows 0 up, last_row set on the final one.
//  - Pen and turn commands take effect at their transfer. A move runs setup and,
//    unless nothing is marked, run and drain: a horizontal move touches one row, a
//    vertical move up to GRID_SIZE rows, one row read-modify-write per cycle through
//    the single grid memory port pair.
//  - Read out streams one row per cycle from the memory read register; the valid
//    flag is registered together with each row read. A low rsp_ready holds the
//    current row and stops further reads.
//  - The request side reopens as soon as the last row read is issued; a following
//    move waits in setup until that row has been taken.
//  - Reset (synchronous) clears pen, heading, position and one valid bit per grid
//    row; an invalid row reads as all clear, so there is no clearing pass.
`include "turtle_plotter_raster_assert.svh"

module turtle_plotter_raster
   import tpr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam logic signed [EXT_W-1:0] ONE_EXT       = EXT_W'(1);
   localparam logic signed [EXT_W-1:0] GRID_LAST_EXT = EXT_W'(GRID_SIZE - 1);
   localparam logic signed [EXT_W-1:0] POS_MAX_EXT   = EXT_W'(32767);
   localparam logic signed [EXT_W-1:0] POS_MIN_EXT   = -EXT_W'(32768);
   localparam logic [IDX_W-1:0]        ROW_LAST      = IDX_W'(GRID_SIZE - 1);

   // grid storage
   logic [ROW_W-1:0]     grid_mem [GRID_SIZE];
   logic [GRID_SIZE-1:0] row_valid_ff;

   // control
   state_type state_ff, state_in;
   logic pen_ff;
   logic [1:0] heading_ff;
   logic signed [POS_W-1:0] pos_x_ff, pos_y_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic wr_pend_ff, wr_pend_in;

   // payload
   logic [STEPS_W-1:0] steps_ff;
   logic [IDX_W-1:0]   row_ff, row_end_ff, wr_row_ff, rsp_row_ff;
   logic [ROW_W-1:0]   mask_ff, rd_ff;
   logic               rd_valid_ff;

   logic req_xfer, rd_en, rd_go, setup_go, empty_move;
   logic [IDX_W-1:0] rd_addr;

   // ---------------------------------------------------------------
   // Move setup: clip the path to the grid and build the row mask
   // ---------------------------------------------------------------
   logic vert, plus;
   logic signed [EXT_W-1:0] n_ext, axis, other, lo, hi, lo_c, hi_c, axis_new, axis_sat;
   logic other_ok;
   logic [IDX_W-1:0] lo_idx, hi_idx, other_idx;
   logic [SH_W-1:0]  top_sh;
   logic [ROW_W-1:0] span_mask, one_mask;

   assign vert     = heading_ff[0];   // +x / -x walk over rows
   assign plus     = (heading_ff == HEAD_POS_X) || (heading_ff == HEAD_POS_Y);
   assign n_ext    = signed'({{(EXT_W-STEPS_W){1'b0}}, steps_ff});
   assign axis     = vert ? EXT_W'(pos_x_ff) : EXT_W'(pos_y_ff);
   assign other    = vert ? EXT_W'(pos_y_ff) : EXT_W'(pos_x_ff);
   assign lo       = plus ? axis : axis - n_ext + ONE_EXT;
   assign hi       = plus ? axis + n_ext - ONE_EXT : axis;
   assign lo_c     = lo[EXT_W-1] ? '0 : lo;
   assign hi_c     = (hi > GRID_LAST_EXT) ? GRID_LAST_EXT : hi;
   assign other_ok = !other[EXT_W-1] && (other <= GRID_LAST_EXT);
   assign empty_move = !pen_ff || (steps_ff == '0) || !other_ok || (lo_c > hi_c);

   assign lo_idx    = lo_c[IDX_W-1:0];
   assign hi_idx    = hi_c[IDX_W-1:0];
   assign other_idx = other[IDX_W-1:0];
   assign top_sh    = SH_W'(ROW_W - 1) - SH_W'(hi_idx);
   assign span_mask = ({ROW_W{1'b1}} << lo_idx) & ({ROW_W{1'b1}} >> top_sh);
   assign one_mask  = {{(ROW_W-1){1'b0}}, 1'b1} << other_idx;

   // position advance with saturation
   assign axis_new = plus ? axis + n_ext : axis - n_ext;
   assign axis_sat = (axis_new > POS_MAX_EXT) ? POS_MAX_EXT :
                     (axis_new < POS_MIN_EXT) ? POS_MIN_EXT : axis_new;

   // ---------------------------------------------------------------
   // Handshake terms
   // ---------------------------------------------------------------
   assign req_xfer = req_valid && req_ready;
   assign rd_go    = !rsp_valid_ff || rsp_ready;
   assign setup_go = (state_ff == ST_MOVE_SETUP) && !rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_payload.kind == KIND_MOVE)) begin
               state_in = ST_MOVE_SETUP;
            end else if (req_xfer && (req_payload.kind == KIND_READ_OUT)) begin
               state_in = ST_DUMP;
            end
         end
         ST_MOVE_SETUP: begin
            if (!rsp_valid_ff) begin
               state_in = empty_move ? ST_IDLE : ST_MOVE_RUN;
            end
         end
         ST_MOVE_RUN: begin
            if (row_ff == row_end_ff) begin
               state_in = ST_MOVE_DRAIN;
            end
         end
         ST_MOVE_DRAIN: state_in = ST_IDLE;
         ST_DUMP: begin
            if (rd_go && (row_ff == ROW_LAST)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = row_ff;
      case (state_ff)
         ST_IDLE:     req_ready = 1'b1;
         ST_MOVE_RUN: rd_en     = 1'b1;
         ST_DUMP:     rd_en     = rd_go;
         default: begin
            req_ready = 1'b0;
            rd_en     = 1'b0;
         end
      endcase
   end

   // result valid: set on each row read issued by read out, cleared on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((state_ff == ST_DUMP) && rd_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // a row read during a move is written back in the next cycle
   assign wr_pend_in = (state_ff == ST_MOVE_RUN);

   // ---------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pen_ff       <= 1'b0;
         heading_ff   <= HEAD_POS_X;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         wr_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_pend_ff   <= wr_pend_in;
         if (req_xfer) begin
            case (req_payload.kind)
               KIND_PEN_UP:   pen_ff     <= 1'b0;
               KIND_PEN_DOWN: pen_ff     <= 1'b1;
               KIND_TURN_R:   heading_ff <= heading_ff + 2'd1;
               KIND_TURN_L:   heading_ff <= heading_ff + 2'd3;
               default:       pen_ff     <= pen_ff;
            endcase
         end
         if (setup_go) begin
            if (vert) begin
               pos_x_ff <= axis_sat[POS_W-1:0];
            end else begin
               pos_y_ff <= axis_sat[POS_W-1:0];
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Sequencer payload registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         steps_ff <= req_payload.steps;
         row_ff   <= '0;
      end else if (setup_go) begin
         row_ff     <= vert ? lo_idx : other_idx;
         row_end_ff <= vert ? hi_idx : other_idx;
         mask_ff    <= vert ? one_mask : span_mask;
      end else if (rd_en) begin
         row_ff <= row_ff + IDX_W'(1);
      end
      if (rd_en) begin
         wr_row_ff  <= row_ff;
         rsp_row_ff <= row_ff;
      end
   end

   // ---------------------------------------------------------------
   // Grid memory: one read port (registered), one write port
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (wr_pend_ff) begin
         grid_mem[wr_row_ff] <= (rd_valid_ff ? rd_ff : '0) | mask_ff;
      end
      if (rd_en) begin
         rd_ff <= grid_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (wr_pend_ff) begin
         row_valid_ff[wr_row_ff] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Result channel, straight from the memory read register
   // ---------------------------------------------------------------
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_payload.row_index = RIDX_W'(rsp_row_ff);
   assign rsp_payload.row_bits  = rd_valid_ff ? (rd_ff & GRID_MASK) : '0;
   assign rsp_payload.last_row  = (rsp_row_ff == ROW_LAST);

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // move pipeline never reads the row it is writing back
   `TPR_ASSERT_IMPLIES(a_no_rw_same_row, wr_pend_ff && rd_en, rd_addr != wr_row_ff)
   // commands are only taken once every write-back has landed
   `TPR_ASSERT_IMPLIES(a_idle_no_wr, req_ready, !wr_pend_ff)
   // a move never overwrites a row still waiting on the result channel
   `TPR_ASSERT_IMPLIES(a_move_keeps_rsp, state_ff == ST_MOVE_RUN, !rsp_valid_ff)
   // results are only pending during or right after a read out
   `TPR_ASSERT_IMPLIES(a_rsp_states, rsp_valid_ff,
      (state_ff == ST_DUMP) || (state_ff == ST_IDLE) || (state_ff == ST_MOVE_SETUP))

endmodule

@@ tb/turtle_plotter_raster_tb.sv @@
// Testbench for turtle_plotter_raster: directed command script, then random commands.
// Expected grid rows come from an in-bench turtle model; needs rtl/tpr_pkg.sv and the RTL.
// Both channels idle and stall at random; results are checked in order, field by field.
module turtle_plotter_raster_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tpr_pkg::*;

   // kinds that the block must ignore
   localparam logic [KIND_W-1:0] KIND_UNUSED_6 = 3'd6;
   localparam logic [KIND_W-1:0] KIND_UNUSED_7 = 3'd7;

   localparam int POS_HI = 32767;
   localparam int POS_LO = -32768;
   localparam int N_SCRIPT = 25;
   localparam int N_RANDOM = 60;
   // longest move: setup, drain and one row per cycle
   localparam int SETTLE_CYCLES = GRID_SIZE + 16;

   // one line of the directed script; typed rows carry the value every grid row must read
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [STEPS_W-1:0] steps;
      logic [9:0]         reps;
      logic               typed;
      logic [ROW_W-1:0]   typed_bits;
   } script_row_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   // turtle model state
   logic [ROW_W-1:0] canvas [GRID_SIZE];
   int               turtle_x;
   int               turtle_y;
   logic [1:0]       turtle_heading;
   logic             turtle_pen;

   rsp_payload_type  pending_rows[$];
   int               errors = 0;

   // pen down, draw along x, then box the origin; pen up, leave the grid toward
   // negative x and draw back in from there, then leave toward negative y
   script_row_type script [N_SCRIPT] = '{
      '{KIND_READ_OUT, 8'd0,   10'd1,   1'b1, 64'h0},  // blank grid after reset
      '{KIND_PEN_DOWN, 8'd0,   10'd1,   1'b0, 64'h0},
      '{KIND_MOVE,     8'd0,   10'd1,   1'b0, 64'h0},  // zero steps: no change
      '{KIND_MOVE,     8'd255, 10'd1,   1'b0, 64'h0},  // column 0 of every row, runs off grid
      '{KIND_READ_OUT, 8'd0,   10'd1,   1'b1, 64'h1},
      '{KIND_TURN_R,   8'd0,   10'd1,   1'b0, 64'h0},
      '{KIND_MOVE,     8'd255, 10'd1,   1'b0, 64'h0},  // entirely off grid
      '{KIND_TURN_R,   8'd0,   10'd1,   1'b0, 64'h0},
      '{KIND_MOVE,     8'd255, 10'd1,   1'b0, 64'h0},
      '{KIND_TURN_R,   8'd255, 10'd1,   1'b0, 64'h0},
      '{KIND_MOVE,     8'd255, 10'd1,   1'b0, 64'h0},  // enters row 0 from above
      '{KIND_READ_OUT, 8'd255, 10'd1,   1'b0, 64'h0},
      '{KIND_TURN_L,   8'd170, 10'd5,   1'b0, 64'h0},  // wraps 0 -> 3
      '{KIND_PEN_UP,   8'd85,  10'd1,   1'b0, 64'h0},
      '{KIND_MOVE,     8'd200, 10'd1,   1'b0, 64'h0},  // x goes negative
      '{KIND_UNUSED_6, 8'd255, 10'd1,   1'b0, 64'h0},
      '{KIND_UNUSED_7, 8'd0,   10'd1,   1'b0, 64'h0},
      '{KIND_TURN_L,   8'd0,   10'd1,   1'b0, 64'h0},  // toward +y
      '{KIND_MOVE,     8'd9,   10'd1,   1'b0, 64'h0},
      '{KIND_TURN_L,   8'd0,   10'd1,   1'b0, 64'h0},  // toward +x
      '{KIND_PEN_DOWN, 8'd0,   10'd1,   1'b0, 64'h0},
      '{KIND_MOVE,     8'd230, 10'd1,   1'b0, 64'h0},  // path enters the grid from negative x
      '{KIND_TURN_L,   8'd0,   10'd1,   1'b0, 64'h0},  // toward -y
      '{KIND_MOVE,     8'd255, 10'd1,   1'b0, 64'h0},  // path leaves toward negative y
      '{KIND_READ_OUT, 8'd0,   10'd1,   1'b0, 64'h0}
   };

   turtle_plotter_raster uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   function automatic int clamp_pos(input int v);
      if (v > POS_HI) return POS_HI;
      if (v < POS_LO) return POS_LO;
      return v;
   endfunction

   function automatic bit on_grid(input int v);
      return v >= 0 && v < GRID_SIZE;
   endfunction

   // gap before the next transfer; quiet stretches have none
   function automatic int draw_wait(input bit quiet);
      return quiet ? 0 : int'($urandom_range(0, 19));
   endfunction

   // Advance the turtle model by one accepted command. A read out queues one row per
   // grid row, either from the model or from the value typed into the script.
   task automatic plot_command(input req_payload_type cmd, input logic typed,
                               input logic [ROW_W-1:0] typed_bits);
      int dx;
      int dy;
      int n;
      int cx;
      int cy;
      rsp_payload_type row;
      dx = 0;
      dy = 0;
      n  = int'(cmd.steps);
      case (cmd.kind)
         KIND_PEN_UP:   turtle_pen = 1'b0;
         KIND_PEN_DOWN: turtle_pen = 1'b1;
         KIND_TURN_R:   turtle_heading = turtle_heading + 2'd1;
         KIND_TURN_L:   turtle_heading = turtle_heading + 2'd3;
         KIND_MOVE: begin
            case (turtle_heading)
               HEAD_NEG_Y: dy = -1;
               HEAD_POS_X: dx = 1;
               HEAD_POS_Y: dy = 1;
               default:    dx = -1;
            endcase
            // the path starts on the current cell and stops one short of the end point
            if (turtle_pen) begin
               for (int k = 0; k < n; k++) begin
                  cx = turtle_x + dx * k;
                  cy = turtle_y + dy * k;
                  if (on_grid(cx) && on_grid(cy))
                     canvas[cx][cy] = 1'b1;
               end
            end
            turtle_x = clamp_pos(turtle_x + dx * n);
            turtle_y = clamp_pos(turtle_y + dy * n);
         end
         KIND_READ_OUT: begin
            for (int r = 0; r < GRID_SIZE; r++) begin
               row.row_index = RIDX_W'(r);
               row.row_bits  = typed ? typed_bits : (canvas[r] & GRID_MASK);
               row.last_row  = (r == GRID_SIZE - 1);
               pending_rows.push_back(row);
            end
         end
         default: ;  // unused kinds are ignored
      endcase
   endtask

   // Sender side. Entered and left at a rising edge, just after a transfer (or reset).
   bit send_quiet;
   int send_count = 0;

   task automatic issue_command(input logic [KIND_W-1:0] kind, input logic [STEPS_W-1:0] steps,
                                input logic typed = 1'b0,
                                input logic [ROW_W-1:0] typed_bits = '0);
      int gap;
      req_payload_type cmd;
      if (send_count % 32 == 0)
         send_quiet = ($urandom_range(0, 3) == 0);
      send_count++;
      gap = draw_wait(send_quiet);
      cmd.kind  = kind;
      cmd.steps = steps;
      // with no gap, valid simply stays high into the next command
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= cmd;
      do @(posedge clock); while (!req_ready);
      plot_command(cmd, typed, typed_bits);
   endtask

   // hold off new commands until every queued row has been taken; always waits on
   // the clock before testing, so the caller's next drive lands in a later time step
   task automatic drain_rows();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rows.size() != 0);
   endtask

   // Steer the turtle back onto the grid: turn toward a random on-grid target on the
   // off-grid axis, then move there in chunks of at most 255 steps.
   task automatic home_turtle();
      int target;
      int travel;
      logic [1:0] want_head;
      logic [1:0] delta;
      while (!on_grid(turtle_x) || !on_grid(turtle_y)) begin
         target = int'($urandom_range(0, GRID_SIZE - 1));
         if (!on_grid(turtle_x)) begin
            travel    = target - turtle_x;
            want_head = (travel > 0) ? HEAD_POS_X : HEAD_NEG_X;
         end else begin
            travel    = target - turtle_y;
            want_head = (travel > 0) ? HEAD_POS_Y : HEAD_NEG_Y;
         end
         if (travel < 0)
            travel = -travel;
         while (turtle_heading != want_head) begin
            delta = want_head - turtle_heading;
            issue_command((delta == 2'd3) ? KIND_TURN_L : KIND_TURN_R,
                          STEPS_W'($urandom_range(0, 255)));
         end
         while (travel > 0) begin
            issue_command(KIND_MOVE, STEPS_W'((travel > 255) ? 255 : travel));
            travel -= (travel > 255) ? 255 : travel;
         end
      end
   endtask

   // Reset, directed script, random commands, then the final verdict.
   initial begin
      int pick;
      logic [STEPS_W-1:0] steps;
      for (int r = 0; r < GRID_SIZE; r++)
         canvas[r] = '0;
      turtle_x       = 0;
      turtle_y       = 0;
      turtle_heading = HEAD_POS_X;
      turtle_pen     = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i])
         repeat (script[i].reps)
            issue_command(script[i].kind, script[i].steps, script[i].typed,
                          script[i].typed_bits);

      // let the whole read out go before anything else
      drain_rows();

      // Random part: mostly short moves near the grid, some long ones, turns, pen
      // changes, a few read outs and ignored kinds. Off-grid turtles are usually homed.
      for (int i = 0; i < N_RANDOM; i++) begin
         if ($urandom_range(0, 19) == 0)
            drain_rows();
         pick = int'($urandom_range(0, 99));
         steps = ($urandom_range(0, 9) == 0) ? STEPS_W'($urandom_range(0, 255))
                                             : STEPS_W'($urandom_range(0, 40));
         if (pick < 45)
            issue_command(KIND_MOVE, steps);
         else if (pick < 55)
            issue_command(KIND_TURN_R, STEPS_W'($urandom_range(0, 255)));
         else if (pick < 65)
            issue_command(KIND_TURN_L, STEPS_W'($urandom_range(0, 255)));
         else if (pick < 72)
            issue_command(KIND_PEN_UP, STEPS_W'($urandom_range(0, 255)));
         else if (pick < 84)
            issue_command(KIND_PEN_DOWN, STEPS_W'($urandom_range(0, 255)));
         else if (pick < 93)
            issue_command(KIND_READ_OUT, STEPS_W'($urandom_range(0, 255)));
         else
            issue_command($urandom_range(0, 1) ? KIND_UNUSED_7 : KIND_UNUSED_6,
                          STEPS_W'($urandom_range(0, 255)));
         if ((!on_grid(turtle_x) || !on_grid(turtle_y)) && $urandom_range(0, 4) != 0)
            home_turtle();
      end
      issue_command(KIND_READ_OUT, 8'd0);

      drain_rows();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && pending_rows.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Receiver side: stall a random number of cycles before each row, with quiet stretches.
   initial begin
      int stall;
      int taken;
      bit quiet;
      taken = 0;
      quiet = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (taken % 32 == 0)
            quiet = ($urandom_range(0, 3) == 0);
         taken++;
         stall = draw_wait(quiet);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Each row transfer is matched against the oldest queued row.
   always @(posedge clock) begin : row_check
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rows.size() == 0) begin
            $error("unexpected row transfer: row_index %0d", rsp_payload.row_index);
            errors++;
         end else begin
            want = pending_rows.pop_front();
            if (rsp_payload.row_index !== want.row_index) begin
               $error("row_index: expected %0d, got %0d", want.row_index,
                      rsp_payload.row_index);
               errors++;
            end
            if (rsp_payload.row_bits !== want.row_bits) begin
               $error("row_bits: expected %h, got %h", want.row_bits, rsp_payload.row_bits);
               errors++;
            end
            if (rsp_payload.last_row !== want.last_row) begin
               $error("last_row: expected %b, got %b", want.last_row, rsp_payload.last_row);
               errors++;
            end
         end
      end
   end

   // hang guard
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
